// ===== sv/blpg_pkg.sv =====
// Shared types and constants for the Bresenham line pixel generator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package blpg_pkg;

    // Width of the screen width, screen height and row stride registers and of the configuration data port.
    localparam int unsigned CFG_BITS    = 13;
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam int unsigned COLOR_BITS  = 8;
    localparam int unsigned OFFSET_BITS = 24;
    localparam int unsigned VALUE_BITS  = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_STRIDE     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRUECOLOR_MODE = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd320;
    localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd200;
    localparam logic [CFG_BITS-1:0] ROW_STRIDE_RESET    = 13'd320;

    // Operation codes of an input transaction.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic [CFG_BITS-1:0] screen_width;
        logic [CFG_BITS-1:0] screen_height;
        logic [CFG_BITS-1:0] row_stride;
        logic                truecolor_mode;
    } cfg_t;

    localparam logic [VALUE_BITS-1:0] PALETTE_RGB [16] = '{
        32'h0000_0000, 32'h0000_00AA, 32'h0000_AA00, 32'h0000_AAAA,
        32'h00AA_0000, 32'h00AA_00AA, 32'h00AA_5500, 32'h00AA_AAAA,
        32'h0055_5555, 32'h0055_55FF, 32'h0055_FF55, 32'h0055_FFFF,
        32'h00FF_5555, 32'h00FF_55FF, 32'h00FF_FF55, 32'h00FF_FFFF
    };

    function automatic logic [VALUE_BITS-1:0] pixel_colour(
        input logic [COLOR_BITS-1:0] color,
        input logic                  truecolor
    );
        logic [VALUE_BITS-1:0] result;
        if (truecolor)
            result = PALETTE_RGB[color[3:0]];
        else
            result = {{(VALUE_BITS-COLOR_BITS){1'b0}}, color};
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== sv/blpg_if.sv =====
// Valid/ready channel interfaces for line commands and generated pixels.
// Depends on blpg_pkg for the fixed field widths.
`default_nettype none

interface blpg_in_if #(
    parameter int COORD_BITS = 13
);
    import blpg_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        color_index;

    modport source (
        output valid, op, start_x, start_y, end_x, end_y, color_index,
        input  ready
    );
    modport sink (
        input  valid, op, start_x, start_y, end_x, end_y, color_index,
        output ready
    );
endinterface

interface blpg_out_if #(
    parameter int COORD_BITS = 13
);
    import blpg_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         in_bounds;
    logic [OFFSET_BITS-1:0]       pixel_offset;
    logic [VALUE_BITS-1:0]        pixel_value;
    logic                         last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, in_bounds, pixel_offset, pixel_value, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, in_bounds, pixel_offset, pixel_value, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/blpg_pixel_calc.sv =====
// Per-pixel attributes: screen clipping, framebuffer offset and pixel value.
// Depends on blpg_pkg for the configuration struct and the palette.
`default_nettype none

module blpg_pixel_calc #(
    parameter int COORD_BITS = 13
) (
    input  wire logic signed [COORD_BITS-1:0]      cur_x,
    input  wire logic signed [COORD_BITS-1:0]      cur_y,
    input  wire logic [blpg_pkg::COLOR_BITS-1:0]   line_color,
    input  wire blpg_pkg::cfg_t                    cfg,
    output logic                                   in_bounds,
    output logic [blpg_pkg::OFFSET_BITS-1:0]       pixel_offset,
    output logic [blpg_pkg::VALUE_BITS-1:0]        pixel_value
);
    import blpg_pkg::*;

    localparam int unsigned CMP_BITS = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
    localparam int unsigned SUM_BITS = (COORD_BITS - 1 + CFG_BITS + 1 > OFFSET_BITS)
                                     ? (COORD_BITS - 1 + CFG_BITS + 1) : OFFSET_BITS;

    logic [CMP_BITS-1:0] x_cmp;
    logic [CMP_BITS-1:0] y_cmp;
    logic [CMP_BITS-1:0] width_cmp;
    logic [CMP_BITS-1:0] height_cmp;
    logic [SUM_BITS-1:0] row_base;
    logic [SUM_BITS-1:0] offset_sum;

    // A negative coordinate has its sign bit set and is rejected before the
    // unsigned compare, so the low bits can be treated as a magnitude.
    assign x_cmp      = CMP_BITS'(unsigned'(cur_x[COORD_BITS-2:0]));
    assign y_cmp      = CMP_BITS'(unsigned'(cur_y[COORD_BITS-2:0]));
    assign width_cmp  = CMP_BITS'(cfg.screen_width);
    assign height_cmp = CMP_BITS'(cfg.screen_height);

    always_comb
    begin
        in_bounds = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1] &&
                    (x_cmp < width_cmp) && (y_cmp < height_cmp);
        row_base   = SUM_BITS'(cur_y[COORD_BITS-2:0]) * SUM_BITS'(cfg.row_stride);
        offset_sum = row_base + SUM_BITS'(cur_x[COORD_BITS-2:0]);
        pixel_offset = in_bounds ? offset_sum[OFFSET_BITS-1:0] : '0;
        pixel_value  = pixel_colour(line_color, cfg.truecolor_mode);
    end

endmodule

`default_nettype wire

// ===== sv/bresenham_line_pixel_gen_core.sv =====
// Top level of the Bresenham line pixel generator: configuration registers,
// line stepping state and the result register.
// Depends on blpg_pkg, blpg_if.sv and blpg_pixel_calc.
`default_nettype none

// A start transaction loads two endpoints and a colour and produces no pixel;
// each following step transaction produces one pixel of the line, from start
// to end, and steps after the end pixel produce nothing. The block takes one
// transaction per clock cycle: each step's pixel and the next Bresenham error
// term are formed in the same cycle and captured in the result register and the
// line state, and a new transaction is accepted whenever that result register
// is empty or is being drained. The longest path is the row times stride
// multiply and column add of the framebuffer offset. Configuration is written
// through cfg_we, cfg_index and cfg_data and takes effect on the next pixel.

module bresenham_line_pixel_gen_core #(
    parameter int COORD_BITS = 13
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [blpg_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [blpg_pkg::CFG_BITS-1:0]     cfg_data,
    blpg_in_if.sink                              in_ch,
    blpg_out_if.source                           out_ch
);
    import blpg_pkg::*;

    localparam int unsigned DX_BITS  = COORD_BITS + 1;
    localparam int unsigned DY_BITS  = COORD_BITS + 2;
    localparam int unsigned ERR_BITS = COORD_BITS + 3;
    localparam int unsigned E2_BITS  = COORD_BITS + 4;

    // Configuration registers.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width   <= SCREEN_WIDTH_RESET;
            cfg_reg.screen_height  <= SCREEN_HEIGHT_RESET;
            cfg_reg.row_stride     <= ROW_STRIDE_RESET;
            cfg_reg.truecolor_mode <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:   cfg_reg.screen_width   <= cfg_data;
                CFG_SCREEN_HEIGHT:  cfg_reg.screen_height  <= cfg_data;
                CFG_ROW_STRIDE:     cfg_reg.row_stride     <= cfg_data;
                CFG_TRUECOLOR_MODE: cfg_reg.truecolor_mode <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Line state.
    logic signed [COORD_BITS-1:0] cur_x_reg,  cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg,  cur_y_next;
    logic signed [COORD_BITS-1:0] goal_x_reg, goal_x_next;
    logic signed [COORD_BITS-1:0] goal_y_reg, goal_y_next;
    logic        [DX_BITS-1:0]    abs_dx_reg, abs_dx_next;
    logic signed [DY_BITS-1:0]    neg_dy_reg, neg_dy_next;
    logic signed [ERR_BITS-1:0]   err_reg,    err_next;
    logic                         dir_x_neg_reg, dir_x_neg_next;
    logic                         dir_y_neg_reg, dir_y_neg_next;
    logic                         line_active_reg, line_active_next;
    logic [COLOR_BITS-1:0]        line_color_reg, line_color_next;

    // Result register.
    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] pixel_x_reg;
    logic signed [COORD_BITS-1:0] pixel_y_reg;
    logic                         in_bounds_reg;
    logic [OFFSET_BITS-1:0]       pixel_offset_reg;
    logic [VALUE_BITS-1:0]        pixel_value_reg;
    logic                         last_pixel_reg;

    logic in_ready;
    logic in_fire;
    logic step_fire;
    logic at_goal;

    logic                         calc_in_bounds;
    logic [OFFSET_BITS-1:0]       calc_offset;
    logic [VALUE_BITS-1:0]        calc_value;

    logic signed [DX_BITS-1:0]    dx;
    logic signed [DY_BITS-1:0]    dy;
    logic signed [E2_BITS-1:0]    e2;
    logic signed [E2_BITS-1:0]    abs_dx_ext;
    logic signed [E2_BITS-1:0]    neg_dy_ext;
    logic                         step_x;
    logic                         step_y;
    logic signed [ERR_BITS-1:0]   err_add_x;
    logic signed [ERR_BITS-1:0]   err_add_y;

    assign in_ready  = !out_valid_reg || out_ch.ready;
    assign in_fire   = in_ch.valid && in_ready;
    assign step_fire = in_fire && (in_ch.op == OP_STEP) && line_active_reg;
    assign at_goal   = (cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg);

    assign in_ch.ready = in_ready;

    blpg_pixel_calc #(
        .COORD_BITS (COORD_BITS)
    ) u_pixel_calc (
        .cur_x        (cur_x_reg),
        .cur_y        (cur_y_reg),
        .line_color   (line_color_reg),
        .cfg          (cfg_reg),
        .in_bounds    (calc_in_bounds),
        .pixel_offset (calc_offset),
        .pixel_value  (calc_value)
    );

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        goal_x_next      = goal_x_reg;
        goal_y_next      = goal_y_reg;
        abs_dx_next      = abs_dx_reg;
        neg_dy_next      = neg_dy_reg;
        err_next         = err_reg;
        dir_x_neg_next   = dir_x_neg_reg;
        dir_y_neg_next   = dir_y_neg_reg;
        line_active_next = line_active_reg;
        line_color_next  = line_color_reg;

        // Start set-up: deltas with the signs folded so that one error term
        // serves every octant.
        dx = DX_BITS'(in_ch.end_x) - DX_BITS'(in_ch.start_x);
        dy = DY_BITS'(in_ch.end_y) - DY_BITS'(in_ch.start_y);

        // Bresenham step: the doubled error decides which axes advance.
        e2         = E2_BITS'(err_reg) <<< 1;
        abs_dx_ext = signed'(E2_BITS'(abs_dx_reg));
        neg_dy_ext = E2_BITS'(neg_dy_reg);
        step_x     = e2 >= neg_dy_ext;
        step_y     = e2 <= abs_dx_ext;
        err_add_x  = step_x ? ERR_BITS'(neg_dy_reg) : '0;
        err_add_y  = step_y ? signed'(ERR_BITS'(abs_dx_reg)) : '0;

        if (in_fire && (in_ch.op == OP_START))
        begin
            abs_dx_next      = dx[DX_BITS-1] ? DX_BITS'(-dx) : DX_BITS'(dx);
            neg_dy_next      = (dy > 0) ? -dy : dy;
            err_next         = signed'(ERR_BITS'(abs_dx_next)) + ERR_BITS'(neg_dy_next);
            dir_x_neg_next   = !(in_ch.start_x < in_ch.end_x);
            dir_y_neg_next   = !(in_ch.start_y < in_ch.end_y);
            cur_x_next       = in_ch.start_x;
            cur_y_next       = in_ch.start_y;
            goal_x_next      = in_ch.end_x;
            goal_y_next      = in_ch.end_y;
            line_color_next  = in_ch.color_index;
            line_active_next = 1'b1;
        end
        else if (step_fire)
        begin
            if (at_goal)
            begin
                line_active_next = 1'b0;
            end
            else
            begin
                err_next = err_reg + err_add_x + err_add_y;
                if (step_x)
                    cur_x_next = dir_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                if (step_y)
                    cur_y_next = dir_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            goal_x_reg      <= '0;
            goal_y_reg      <= '0;
            abs_dx_reg      <= '0;
            neg_dy_reg      <= '0;
            err_reg         <= '0;
            dir_x_neg_reg   <= 1'b0;
            dir_y_neg_reg   <= 1'b0;
            line_active_reg <= 1'b0;
            line_color_reg  <= '0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            goal_x_reg      <= goal_x_next;
            goal_y_reg      <= goal_y_next;
            abs_dx_reg      <= abs_dx_next;
            neg_dy_reg      <= neg_dy_next;
            err_reg         <= err_next;
            dir_x_neg_reg   <= dir_x_neg_next;
            dir_y_neg_reg   <= dir_y_neg_next;
            line_active_reg <= line_active_next;
            line_color_reg  <= line_color_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            pixel_x_reg      <= cur_x_reg;
            pixel_y_reg      <= cur_y_reg;
            in_bounds_reg    <= calc_in_bounds;
            pixel_offset_reg <= calc_offset;
            pixel_value_reg  <= calc_value;
            last_pixel_reg   <= at_goal;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.pixel_x      = pixel_x_reg;
    assign out_ch.pixel_y      = pixel_y_reg;
    assign out_ch.in_bounds    = in_bounds_reg;
    assign out_ch.pixel_offset = pixel_offset_reg;
    assign out_ch.pixel_value  = pixel_value_reg;
    assign out_ch.last_pixel   = last_pixel_reg;

    // A clipped pixel never carries a framebuffer offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !in_bounds_reg) |-> (pixel_offset_reg == '0))
        else $error("clipped pixel has a non-zero offset");

    // Delivering the end pixel retires the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && at_goal) |=> !line_active_reg)
        else $error("line still active after its last pixel");

    // A start transaction always leaves a line loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_ch.op == OP_START)) |=> line_active_reg)
        else $error("start transaction did not load a line");

    // An empty result register never holds off the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with an empty result register");

    // A result held under back-pressure is not overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !step_fire)
        else $error("pixel produced while the result register was stalled");

endmodule

`default_nettype wire

// ===== dv/tb_bresenham_line_pixel_gen_core.sv =====
// Self-checking testbench for bresenham_line_pixel_gen_core: directed line commands,
// then randomised line sequences under several register settings and idle patterns.
// Depends on blpg_pkg, blpg_if.sv and the RTL of the block.
`timescale 1ns / 100ps

module tb_bresenham_line_pixel_gen_core;
    import blpg_pkg::*;

    localparam int CW = 13;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t                 x;
        coord_t                 y;
        logic                   in_bounds;
        logic [OFFSET_BITS-1:0] offset;
        logic [VALUE_BITS-1:0]  value;
        logic                   last;
    } pixel_t;

    typedef struct packed {
        logic                  op;
        coord_t                sx;
        coord_t                sy;
        coord_t                ex;
        coord_t                ey;
        logic [COLOR_BITS-1:0] color;
    } line_cmd_t;

    typedef struct packed {
        line_cmd_t cmd;
        logic      typed;
        pixel_t    want;
    } script_row_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] width;
        logic [CFG_BITS-1:0] height;
        logic [CFG_BITS-1:0] stride;
        logic                truecolour;
        logic                shuffle;
        logic [6:0]          src_idle;
        logic [6:0]          sink_stall;
        logic                pressure;
    } phase_t;

    localparam logic [VALUE_BITS-1:0] RGB_TABLE [16] = '{
        32'h00000000, 32'h000000AA, 32'h0000AA00, 32'h0000AAAA,
        32'h00AA0000, 32'h00AA00AA, 32'h00AA5500, 32'h00AAAAAA,
        32'h00555555, 32'h005555FF, 32'h0055FF55, 32'h0055FFFF,
        32'h00FF5555, 32'h00FF55FF, 32'h00FFFF55, 32'h00FFFFFF
    };

    localparam pixel_t    NO_PIXEL = '0;
    localparam line_cmd_t STEP     = '{op: OP_STEP, default: '0};

    localparam int SCRIPT_LEN = 24;

    // Directed lines under the reset register values. Rows with typed set carry
    // the pixel by hand; the others are left to the line predictor.
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // a step with no line loaded gives nothing
        '{STEP, 1'b0, NO_PIXEL},
        // a zero-length line is a single pixel, flagged last
        '{'{OP_START, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 8'h5A}, 1'b0, NO_PIXEL},
        '{STEP, 1'b1, '{13'sd0, 13'sd0, 1'b1, 24'd0, 32'h0000005A, 1'b1}},
        '{STEP, 1'b0, NO_PIXEL},
        // diagonal across the bottom right corner of the screen
        '{'{OP_START, 13'sd319, 13'sd199, 13'sd320, 13'sd200, 8'hA7}, 1'b0, NO_PIXEL},
        '{STEP, 1'b1, '{13'sd319, 13'sd199, 1'b1, 24'd63999, 32'h000000A7, 1'b0}},
        '{STEP, 1'b1, '{13'sd320, 13'sd200, 1'b0, 24'd0, 32'h000000A7, 1'b1}},
        // the longest possible line, dropped after two pixels
        '{'{OP_START, 13'h1000, 13'h1000, 13'sd4095, 13'sd4095, 8'hFF}, 1'b0, NO_PIXEL},
        '{STEP, 1'b1, '{13'h1000, 13'h1000, 1'b0, 24'd0, 32'h000000FF, 1'b0}},
        '{STEP, 1'b0, NO_PIXEL},
        '{'{OP_START, 13'sd4095, 13'sd4095, 13'h1000, 13'sd4095, 8'h00}, 1'b0, NO_PIXEL},
        '{STEP, 1'b1, '{13'sd4095, 13'sd4095, 1'b0, 24'd0, 32'h00000000, 1'b0}},
        '{STEP, 1'b0, NO_PIXEL},
        // steep, negative y, clipped on the left
        '{'{OP_START, -13'sd1, 13'sd5, -13'sd1, -13'sd3, 8'h80}, 1'b0, NO_PIXEL},
        '{STEP, 1'b0, NO_PIXEL},
        '{STEP, 1'b0, NO_PIXEL},
        '{STEP, 1'b0, NO_PIXEL},
        // shallow, negative x
        '{'{OP_START, 13'sd10, 13'sd3, 13'sd2, 13'sd7, 8'h3C}, 1'b0, NO_PIXEL},
        '{STEP, 1'b0, NO_PIXEL},
        '{STEP, 1'b0, NO_PIXEL},
        '{STEP, 1'b0, NO_PIXEL},
        // left unfinished so that the colour mode changes in the middle of it
        '{'{OP_START, 13'sd5, 13'sd2, 13'sd9, 13'sd12, 8'h11}, 1'b0, NO_PIXEL},
        '{STEP, 1'b0, NO_PIXEL},
        '{STEP, 1'b0, NO_PIXEL}
    };

    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 250;

    localparam phase_t PHASE_PLAN [PHASES] = '{
        '{13'd8191, 13'd8191, 13'd8191, 1'b1, 1'b0, 7'd0,  7'd0,  1'b0},
        '{13'd0,    13'd200,  13'd1,    1'b0, 1'b0, 7'd83, 7'd0,  1'b0},
        '{13'd64,   13'd0,    13'd4096, 1'b1, 1'b0, 7'd0,  7'd83, 1'b0},
        '{13'd1,    13'd1,    13'd1,    1'b0, 1'b0, 7'd16, 7'd16, 1'b0},
        '{13'd0,    13'd0,    13'd0,    1'b0, 1'b1, 7'd0,  7'd0,  1'b0},
        '{13'd320,  13'd200,  13'd320,  1'b1, 1'b0, 7'd0,  7'd0,  1'b1},
        '{13'd4096, 13'd4096, 13'd1,    1'b0, 1'b0, 7'd16, 7'd16, 1'b0}
    };

    localparam int HOLD_CYCLES = 150;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    blpg_in_if  #(.COORD_BITS(CW)) in_ch ();
    blpg_out_if #(.COORD_BITS(CW)) out_ch ();

    bresenham_line_pixel_gen_core #(.COORD_BITS(CW)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Predictor copy of the registers and the line state.
    logic [CFG_BITS-1:0]   scr_w = 13'd320;
    logic [CFG_BITS-1:0]   scr_h = 13'd200;
    logic [CFG_BITS-1:0]   stride = 13'd320;
    logic                  rgb_mode = 1'b0;
    coord_t                cur_x = '0;
    coord_t                cur_y = '0;
    coord_t                goal_x = '0;
    coord_t                goal_y = '0;
    logic signed [13:0]    run_x = '0;
    logic signed [14:0]    fall_y = '0;
    logic                  back_x = 1'b0;
    logic                  back_y = 1'b0;
    logic signed [15:0]    err = '0;
    logic                  drawing = 1'b0;
    logic [COLOR_BITS-1:0] ink = '0;

    pixel_t      pending_pixels [$];
    int unsigned mismatches = 0;
    int unsigned commands_counted = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_requests = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void note_fail(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    // Advances the line state by one accepted command and gives the pixel it yields.
    task automatic trace_line(input line_cmd_t c, output logic made, output pixel_t px);
        logic signed [13:0] dx;
        logic signed [13:0] dy;
        logic signed [16:0] twice_err;
        logic [31:0]        linear;
        made = 1'b0;
        px = '0;
        if (c.op == OP_START)
        begin
            dx = 14'(c.ex) - 14'(c.sx);
            dy = 14'(c.ey) - 14'(c.sy);
            run_x = (dx < 0) ? -dx : dx;
            fall_y = (dy > 0) ? -15'(dy) : 15'(dy);
            back_x = !(c.sx < c.ex);
            back_y = !(c.sy < c.ey);
            err = 16'(run_x) + 16'(fall_y);
            cur_x = c.sx;
            cur_y = c.sy;
            goal_x = c.ex;
            goal_y = c.ey;
            ink = c.color;
            drawing = 1'b1;
        end
        else if (drawing)
        begin
            made = 1'b1;
            px.x = cur_x;
            px.y = cur_y;
            px.in_bounds = !cur_x[CW-1] && !cur_y[CW-1]
                           && ($unsigned(cur_x) < scr_w) && ($unsigned(cur_y) < scr_h);
            linear = {19'd0, cur_y} * {19'd0, stride} + {19'd0, cur_x};
            px.offset = px.in_bounds ? linear[OFFSET_BITS-1:0] : '0;
            px.value = rgb_mode ? RGB_TABLE[ink[3:0]] : {24'd0, ink};
            px.last = (cur_x == goal_x) && (cur_y == goal_y);
            if (px.last)
                drawing = 1'b0;
            else
            begin
                // Both decisions use the error term from before this step.
                twice_err = {err, 1'b0};
                if (twice_err >= 17'(fall_y))
                begin
                    err = err + 16'(fall_y);
                    cur_x = back_x ? cur_x - 13'sd1 : cur_x + 13'sd1;
                end
                if (twice_err <= 17'(run_x))
                begin
                    err = err + 16'(run_x);
                    cur_y = back_y ? cur_y - 13'sd1 : cur_y + 13'sd1;
                end
            end
        end
    endtask

    // Entered and left at a falling edge; returns once the block has taken the command.
    task automatic push_cmd(input line_cmd_t c, input logic typed, input pixel_t want);
        logic   made;
        pixel_t px;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= c.op;
        in_ch.start_x <= c.sx;
        in_ch.start_y <= c.sy;
        in_ch.end_x <= c.ex;
        in_ch.end_y <= c.ey;
        in_ch.color_index <= c.color;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        trace_line(c, made, px);
        if (made)
            pending_pixels.push_back(typed ? want : px);
        if (c.op == OP_START || made)
            commands_counted++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_SCREEN_WIDTH:   scr_w = data;
            CFG_SCREEN_HEIGHT:  scr_h = data;
            CFG_ROW_STRIDE:     stride = data;
            CFG_TRUECOLOR_MODE: rgb_mode = data[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Waits for every expected pixel, then waits on for a start still in flight.
    task automatic wait_drained();
        int guard;
        guard = 0;
        while (pending_pixels.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic coord_t clamp_coord(input int v);
        if (v < -4096)
            return 13'h1000;
        if (v > 4095)
            return 13'sd4095;
        return coord_t'(v);
    endfunction

    function automatic coord_t near_screen(input logic [CFG_BITS-1:0] limit);
        return clamp_coord(int'($urandom_range(0, int'(limit) + 16)) - 8);
    endfunction

    function automatic coord_t corner_coord();
        case ($urandom_range(0, 6))
            0:       return 13'h1000;
            1:       return 13'h1001;
            2:       return -13'sd1;
            3:       return 13'sd0;
            4:       return 13'sd1;
            5:       return 13'sd4094;
            default: return 13'sd4095;
        endcase
    endfunction

    function automatic int span_of(input coord_t a, input coord_t b);
        int d;
        d = int'(b) - int'(a);
        return (d < 0) ? -d : d;
    endfunction

    task automatic run_random(input int unsigned quota);
        int unsigned target;
        line_cmd_t   c;
        int          reach;
        int          len;
        int          n;
        int unsigned pick;
        target = commands_counted + quota;
        c = STEP;
        // Carry on with whatever line the last phase left unfinished.
        repeat ($urandom_range(1, 3)) push_cmd(c, 1'b0, NO_PIXEL);
        while (commands_counted < target)
        begin
            if ($urandom_range(99) < 6)
            begin
                c.op = OP_STEP;
                push_cmd(c, 1'b0, NO_PIXEL);
            end
            else
            begin
                c.op = OP_START;
                pick = $urandom_range(99);
                if (pick < 50)
                begin
                    c.sx = near_screen(scr_w);
                    c.sy = near_screen(scr_h);
                end
                else if (pick < 80)
                begin
                    c.sx = coord_t'($urandom());
                    c.sy = coord_t'($urandom());
                end
                else
                begin
                    c.sx = corner_coord();
                    c.sy = corner_coord();
                end
                reach = ($urandom_range(99) < 5) ? 300 : 24;
                c.ex = clamp_coord(int'(c.sx) + int'($urandom_range(0, 2 * reach)) - reach);
                c.ey = clamp_coord(int'(c.sy) + int'($urandom_range(0, 2 * reach)) - reach);
                c.color = 8'($urandom());
                push_cmd(c, 1'b0, NO_PIXEL);
                len = span_of(c.sx, c.ex);
                if (span_of(c.sy, c.ey) > len)
                    len = span_of(c.sy, c.ey);
                len++;
                pick = $urandom_range(99);
                if (pick < 70)
                    n = len;
                else if (pick < 85)
                    n = len + int'($urandom_range(1, 3));
                else
                    n = int'($urandom_range(1, len));
                // Step transactions keep the stale endpoint fields, which must be ignored.
                c.op = OP_STEP;
                repeat (n) push_cmd(c, 1'b0, NO_PIXEL);
            end
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        string  bad;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.x = out_ch.pixel_x;
            got.y = out_ch.pixel_y;
            got.in_bounds = out_ch.in_bounds;
            got.offset = out_ch.pixel_offset;
            got.value = out_ch.pixel_value;
            got.last = out_ch.last_pixel;
            if (pending_pixels.size() == 0)
                note_fail($sformatf("unexpected pixel transaction at (%0d,%0d)", got.x, got.y));
            else
            begin
                want = pending_pixels.pop_front();
                bad = "";
                if (got.x !== want.x)
                    bad = {bad, " pixel_x"};
                if (got.y !== want.y)
                    bad = {bad, " pixel_y"};
                if (got.in_bounds !== want.in_bounds)
                    bad = {bad, " in_bounds"};
                if (got.offset !== want.offset)
                    bad = {bad, " pixel_offset"};
                if (got.value !== want.value)
                    bad = {bad, " pixel_value"};
                if (got.last !== want.last)
                    bad = {bad, " last_pixel"};
                if (bad != "")
                    note_fail($sformatf({"mismatch in%s: ",
                        "expected (%0d,%0d) in=%0b off=%06h val=%08h last=%0b, ",
                        "got (%0d,%0d) in=%0b off=%06h val=%08h last=%0b"},
                        bad, want.x, want.y, want.in_bounds, want.offset, want.value, want.last,
                        got.x, got.y, got.in_bounds, got.offset, got.value, got.last));
            end
        end
    end

    // Pixel receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int unsigned holds_served;
        int          hold_left;
        holds_served = 0;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SCREEN_WIDTH;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_STEP;
        in_ch.start_x = '0;
        in_ch.start_y = '0;
        in_ch.end_x = '0;
        in_ch.end_y = '0;
        in_ch.color_index = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            push_cmd(SCRIPT[i].cmd, SCRIPT[i].typed, SCRIPT[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            in_ch.valid <= 1'b0;
            wait_drained();
            if (PHASE_PLAN[p].shuffle)
            begin
                write_reg(CFG_SCREEN_WIDTH, 13'($urandom()));
                write_reg(CFG_SCREEN_HEIGHT, 13'($urandom()));
                write_reg(CFG_ROW_STRIDE, 13'($urandom()));
                write_reg(CFG_TRUECOLOR_MODE, 13'($urandom()));
            end
            else
            begin
                write_reg(CFG_SCREEN_WIDTH, PHASE_PLAN[p].width);
                write_reg(CFG_SCREEN_HEIGHT, PHASE_PLAN[p].height);
                write_reg(CFG_ROW_STRIDE, PHASE_PLAN[p].stride);
                // Upper data bits are junk; only bit 0 selects the colour mode.
                write_reg(CFG_TRUECOLOR_MODE,
                          {12'($urandom()), PHASE_PLAN[p].truecolour});
            end
            cfg_we <= 1'b0;
            src_idle_pct = PHASE_PLAN[p].src_idle;
            sink_stall_pct = PHASE_PLAN[p].sink_stall;
            if (PHASE_PLAN[p].pressure)
                hold_requests++;
            run_random(PHASE_ITEMS);
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (pending_pixels.size() != 0)
            note_fail($sformatf("%0d expected pixel transactions never arrived",
                                pending_pixels.size()));
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== bresenham_line_pixel_gen_core.f =====
sv/blpg_pkg.sv
sv/blpg_if.sv
sv/blpg_pixel_calc.sv
sv/bresenham_line_pixel_gen_core.sv
dv/tb_bresenham_line_pixel_gen_core.sv
